// File: hw/rtl/spc_pkg.sv
package spc_pkg;

    // Angle and output formats
    localparam int ANGLE_BITS = 32;
    localparam int OUT_BITS   = 48;
    localparam int ASH_R      = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
    localparam int ASH_L      = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;

    // Fixed-point constants of the sine and cosine series
    localparam logic [32:0] PI_Q31  = 33'h1_921F_B544;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [29:0] EIGHTH  = 30'h2000_0000;

    // Horner steps: cosine takes N_SLOT steps, sine N_SIN steps and a final product
    localparam int N_SLOT   = 6;
    localparam int N_SIN    = 5;
    localparam int SC_REGS  = 3 + 3 * N_SLOT;
    localparam int SC_DEPTH = SC_REGS + 1;

    localparam logic [7:0] KS [N_SIN]  = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] KC [N_SLOT] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // floor(2^32 / k): reciprocals for the constant divisions
    localparam logic [31:0] MS [N_SIN] = '{
        32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
        32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
        32'(64'd4294967296 / 64'd6)};
    localparam logic [31:0] MC [N_SLOT] = '{
        32'(64'd4294967296 / 64'd132), 32'(64'd4294967296 / 64'd90),
        32'(64'd4294967296 / 64'd56),  32'(64'd4294967296 / 64'd30),
        32'(64'd4294967296 / 64'd12),  32'(64'd4294967296 / 64'd2)};

    // Wide intermediate format and split point of the wide multiplies
    localparam int WIDE_W = 56;
    localparam int LO_W   = 26;
    localparam int HI_W   = WIDE_W - LO_W;

    typedef struct packed {
        logic [31:0]        longitude;
        logic [31:0]        latitude;
        logic signed [31:0] distance;
        logic signed [31:0] longitude_rate;
        logic signed [31:0] latitude_rate;
        logic signed [31:0] distance_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] pos_x;
        logic signed [OUT_BITS-1:0] pos_y;
        logic signed [OUT_BITS-1:0] pos_z;
        logic signed [OUT_BITS-1:0] vel_x;
        logic signed [OUT_BITS-1:0] vel_y;
        logic signed [OUT_BITS-1:0] vel_z;
    } out_item_t;

    // Sine/cosine pipeline stage contents
    typedef struct packed {
        logic [1:0]  quad;
        logic        sw;
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] hs;
        logic [30:0] hc;
        logic [29:0] vs;
        logic [29:0] vc;
        logic [29:0] qs;
        logic [29:0] qc;
    } sc_t;

    // Radial terms delayed alongside the sine/cosine pipeline
    typedef struct packed {
        logic signed [31:0] d;
        logic signed [31:0] dlo;
        logic signed [31:0] dla;
        logic signed [31:0] dd;
    } rd_t;

    // Partial products of a wide by 32-bit multiply
    typedef struct packed {
        logic signed [HI_W+31:0] hi;
        logic signed [LO_W+32:0] lo;
        logic                    neg;
    } pp_t;

endpackage

// File: hw/rtl/spherical_pv_to_cartesian_core.sv
// Spherical position/velocity to Cartesian position/velocity, fully pipelined.
// The pipeline has 22 sine/cosine stages and 9 product and output stages; it takes
// one item per cycle while the output is not stalled.
// Each stage advances when the stage after it is free, so bubbles close up.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
module spherical_pv_to_cartesian_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spc_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spc_pkg::out_item_t   out_data
);

    localparam int SCD = spc_pkg::SC_DEPTH;
    localparam int NST = SCD + 9;
    localparam int E1  = SCD;
    localparam int E2  = SCD + 1;
    localparam int E3  = SCD + 2;
    localparam int E4  = SCD + 3;
    localparam int E5  = SCD + 4;
    localparam int E6  = SCD + 5;
    localparam int E7  = SCD + 6;
    localparam int E8  = SCD + 7;
    localparam int E9  = SCD + 8;
    localparam int W   = spc_pkg::WIDE_W;

    typedef logic signed [W-1:0] wide_t;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    logic signed [31:0] slo, clo, sla, cla;
    spc_pkg::rd_t       rd_reg [SCD];

    // Product and output stage registers
    logic signed [63:0] p_dcl_reg, p_z_reg, p_ddl_reg, p_t2_reg, p_t3_reg;
    logic signed [31:0] clo1_reg, slo1_reg, sla1_reg, cla1_reg, dlo1_reg;
    wide_t              dcl2_reg, z2_reg, ddl2_reg, t22_reg, t32_reg;
    logic signed [31:0] clo2_reg, slo2_reg, sla2_reg, cla2_reg, dlo2_reg;
    spc_pkg::pp_t       ppx3_reg, ppy3_reg, ppw3_reg, ppv3_reg;
    wide_t              z3_reg, t23_reg, t33_reg;
    logic signed [31:0] clo3_reg, slo3_reg, dlo3_reg;
    wide_t              x4_reg, y4_reg, w14_reg, vz14_reg, z4_reg, t24_reg, t34_reg;
    logic signed [31:0] clo4_reg, slo4_reg, dlo4_reg;
    wide_t              x5_reg, y5_reg, z5_reg, w5_reg, vz5_reg;
    spc_pkg::pp_t       ppxd5_reg, ppyd5_reg;
    logic signed [31:0] clo5_reg, slo5_reg;
    wide_t              x6_reg, y6_reg, z6_reg, vz6_reg, xdl6_reg, ydl6_reg;
    spc_pkg::pp_t       ppwc6_reg, ppws6_reg;
    wide_t              x7_reg, y7_reg, z7_reg, vz7_reg, xdl7_reg, ydl7_reg, wc7_reg, ws7_reg;
    wide_t              x8_reg, y8_reg, z8_reg, vz8_reg, vx8_reg, vy8_reg;
    spc_pkg::out_item_t out_reg;

    // Truncate a 64-bit product toward zero by 2^n
    function automatic wide_t trunc64(input logic signed [63:0] p, input int n);
        logic signed [64:0] s;
        logic signed [64:0] bias;
        bias = (65'sd1 <<< n) - 65'sd1;
        s = 65'(p) + (p[63] ? bias : 65'sd0);
        s = s >>> n;
        return s[W-1:0];
    endfunction

    // Split a wide by 32-bit product into two partial products
    function automatic spc_pkg::pp_t mul_split(input wide_t a, input logic signed [31:0] b);
        logic signed [spc_pkg::HI_W-1:0] ah;
        logic signed [spc_pkg::LO_W:0]   al;
        spc_pkg::pp_t                    r;
        ah    = a[W-1:spc_pkg::LO_W];
        al    = $signed({1'b0, a[spc_pkg::LO_W-1:0]});
        r.hi  = ah * b;
        r.lo  = al * b;
        r.neg = a[W-1] ^ b[31];
        return r;
    endfunction

    // Combine partial products and truncate toward zero by 2^n
    function automatic wide_t combine(input spc_pkg::pp_t pp, input int n);
        logic signed [W+31:0] s;
        logic signed [W+31:0] bias;
        bias = ((W+32)'(1) <<< n) - (W+32)'(1);
        s = ((W+32)'(pp.hi) <<< spc_pkg::LO_W) + (W+32)'(pp.lo)
            + (pp.neg ? bias : '0);
        s = s >>> n;
        return s[W-1:0];
    endfunction

    // Drop the fraction to Q32.16 and saturate to the output width
    function automatic logic signed [spc_pkg::OUT_BITS-1:0] emit_q(input wide_t v);
        logic signed [63:0] r;
        logic signed [63:0] omax;
        logic signed [63:0] omin;
        omax = (64'sd1 <<< (spc_pkg::OUT_BITS - 1)) - 64'sd1;
        omin = -omax - 64'sd1;
        r = 64'(v) + (v[W-1] ? 64'sd65535 : 64'sd0);
        r = r >>> 16;
        if (r > omax)
        begin
            r = omax;
        end
        if (r < omin)
        begin
            r = omin;
        end
        return r[spc_pkg::OUT_BITS-1:0];
    endfunction

    // Stage enables: a stage moves when empty or when the next one moves
    assign en[NST-1] = !valid_reg[NST-1] || out_ready;
    for (genvar k = 0; k < NST - 1; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    spc_sincos u_lon (
        .clk   (clk),
        .en    (en[SCD-1:0]),
        .angle (in_data.longitude),
        .sin_q (slo),
        .cos_q (clo)
    );

    spc_sincos u_lat (
        .clk   (clk),
        .en    (en[SCD-1:0]),
        .angle (in_data.latitude),
        .sin_q (sla),
        .cos_q (cla)
    );

    // Delay distance and rates to meet the sines and cosines
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rd_reg[0] <= '{d:   in_data.distance,       dlo: in_data.longitude_rate,
                           dla: in_data.latitude_rate,  dd:  in_data.distance_rate};
        end
        for (int k = 1; k < SCD; k++)
        begin
            if (en[k])
            begin
                rd_reg[k] <= rd_reg[k-1];
            end
        end
    end

    // Products of distance and rate with the latitude terms
    always_ff @(posedge clk)
    begin
        if (en[E1])
        begin
            p_dcl_reg <= rd_reg[SCD-1].d * cla;
            p_z_reg   <= rd_reg[SCD-1].d * sla;
            p_ddl_reg <= rd_reg[SCD-1].d * rd_reg[SCD-1].dla;
            p_t2_reg  <= rd_reg[SCD-1].dd * cla;
            p_t3_reg  <= rd_reg[SCD-1].dd * sla;
            clo1_reg  <= clo;
            slo1_reg  <= slo;
            sla1_reg  <= sla;
            cla1_reg  <= cla;
            dlo1_reg  <= rd_reg[SCD-1].dlo;
        end
    end

    // Scale them
    always_ff @(posedge clk)
    begin
        if (en[E2])
        begin
            dcl2_reg <= trunc64(p_dcl_reg, 14);
            z2_reg   <= trunc64(p_z_reg, 14);
            ddl2_reg <= trunc64(p_ddl_reg, 12);
            t22_reg  <= trunc64(p_t2_reg, 14);
            t32_reg  <= trunc64(p_t3_reg, 14);
            clo2_reg <= clo1_reg;
            slo2_reg <= slo1_reg;
            sla2_reg <= sla1_reg;
            cla2_reg <= cla1_reg;
            dlo2_reg <= dlo1_reg;
        end
    end

    // Partial products for x, y and the latitude-rate terms
    always_ff @(posedge clk)
    begin
        if (en[E3])
        begin
            ppx3_reg <= mul_split(dcl2_reg, clo2_reg);
            ppy3_reg <= mul_split(dcl2_reg, slo2_reg);
            ppw3_reg <= mul_split(ddl2_reg, sla2_reg);
            ppv3_reg <= mul_split(ddl2_reg, cla2_reg);
            z3_reg   <= z2_reg;
            t23_reg  <= t22_reg;
            t33_reg  <= t32_reg;
            clo3_reg <= clo2_reg;
            slo3_reg <= slo2_reg;
            dlo3_reg <= dlo2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[E4])
        begin
            x4_reg   <= combine(ppx3_reg, 30);
            y4_reg   <= combine(ppy3_reg, 30);
            w14_reg  <= combine(ppw3_reg, 30);
            vz14_reg <= combine(ppv3_reg, 30);
            z4_reg   <= z3_reg;
            t24_reg  <= t23_reg;
            t34_reg  <= t33_reg;
            clo4_reg <= clo3_reg;
            slo4_reg <= slo3_reg;
            dlo4_reg <= dlo3_reg;
        end
    end

    // Form w and dz; start the longitude-rate products
    always_ff @(posedge clk)
    begin
        if (en[E5])
        begin
            w5_reg    <= w14_reg - t24_reg;
            vz5_reg   <= vz14_reg + t34_reg;
            ppxd5_reg <= mul_split(x4_reg, dlo4_reg);
            ppyd5_reg <= mul_split(y4_reg, dlo4_reg);
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            z5_reg    <= z4_reg;
            clo5_reg  <= clo4_reg;
            slo5_reg  <= slo4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[E6])
        begin
            xdl6_reg  <= combine(ppxd5_reg, 28);
            ydl6_reg  <= combine(ppyd5_reg, 28);
            ppwc6_reg <= mul_split(w5_reg, clo5_reg);
            ppws6_reg <= mul_split(w5_reg, slo5_reg);
            x6_reg    <= x5_reg;
            y6_reg    <= y5_reg;
            z6_reg    <= z5_reg;
            vz6_reg   <= vz5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[E7])
        begin
            wc7_reg  <= combine(ppwc6_reg, 30);
            ws7_reg  <= combine(ppws6_reg, 30);
            xdl7_reg <= xdl6_reg;
            ydl7_reg <= ydl6_reg;
            x7_reg   <= x6_reg;
            y7_reg   <= y6_reg;
            z7_reg   <= z6_reg;
            vz7_reg  <= vz6_reg;
        end
    end

    // Velocity in the plane
    always_ff @(posedge clk)
    begin
        if (en[E8])
        begin
            vx8_reg <= -ydl7_reg - wc7_reg;
            vy8_reg <= xdl7_reg - ws7_reg;
            x8_reg  <= x7_reg;
            y8_reg  <= y7_reg;
            z8_reg  <= z7_reg;
            vz8_reg <= vz7_reg;
        end
    end

    // Output register: round toward zero and saturate
    always_ff @(posedge clk)
    begin
        if (en[E9])
        begin
            out_reg.pos_x <= emit_q(x8_reg);
            out_reg.pos_y <= emit_q(y8_reg);
            out_reg.pos_z <= emit_q(z8_reg);
            out_reg.vel_x <= emit_q(vx8_reg);
            out_reg.vel_y <= emit_q(vy8_reg);
            out_reg.vel_z <= emit_q(vz8_reg);
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/spc_sincos.sv
module spc_sincos (
    input  logic                             clk,
    input  logic [spc_pkg::SC_DEPTH-1:0]     en,
    input  logic [31:0]                      angle,
    output logic signed [31:0]               sin_q,
    output logic signed [31:0]               cos_q
);

    localparam int NS = spc_pkg::SC_REGS;

    spc_pkg::sc_t       st_reg  [NS];
    spc_pkg::sc_t       st_next [NS];
    logic signed [31:0] sin_reg, sin_next;
    logic signed [31:0] cos_reg, cos_next;

    // One Horner step after the division estimate: correct by one, subtract from one
    function automatic logic [30:0] hstep(input logic [29:0] v, input logic [29:0] qe,
                                          input logic [7:0] k);
        logic [37:0] r;
        logic [29:0] q;
        r = 38'(v) - 38'(qe) * 38'(k);
        q = (r >= 38'(k)) ? qe + 30'd1 : qe;
        return spc_pkg::ONE_Q30 - 31'(q);
    endfunction

    // Reduce the angle to a quadrant and a fold within an eighth turn
    always_comb
    begin : b_reduce
        logic [63:0] t;
        logic [31:0] t32;
        logic [29:0] f;
        st_next[0] = '0;
        t   = {32'd0, angle} & ((64'd1 << spc_pkg::ANGLE_BITS) - 64'd1);
        t   = (t >> spc_pkg::ASH_R) << spc_pkg::ASH_L;
        t32 = t[31:0];
        f   = t32[29:0];
        st_next[0].quad = t32[31:30];
        st_next[0].sw   = (f > spc_pkg::EIGHTH);
        st_next[0].x    = st_next[0].sw ? 30'(spc_pkg::ONE_Q30 - {1'b0, f}) : f;
    end

    // Scale the fold to radians
    always_comb
    begin : b_rad
        logic [62:0] p;
        st_next[1]   = st_reg[0];
        p            = 63'(st_reg[0].x) * 63'(spc_pkg::PI_Q31);
        st_next[1].x = p[61:32];
    end

    // Square and start both series at one
    always_comb
    begin : b_sq
        logic [59:0] p;
        st_next[2]    = st_reg[1];
        p             = 60'(st_reg[1].x) * 60'(st_reg[1].x);
        st_next[2].x2 = p[59:30];
        st_next[2].hs = spc_pkg::ONE_Q30;
        st_next[2].hc = spc_pkg::ONE_Q30;
    end

    // Horner steps: product, reciprocal estimate, correction
    for (genvar j = 3; j < NS; j++)
    begin : g_step
        localparam int SL = (j - 3) / 3;
        localparam int PH = (j - 3) % 3;
        if (PH == 0)
        begin : g_prod
            always_comb
            begin
                logic [60:0] ps;
                logic [60:0] pc;
                st_next[j] = st_reg[j-1];
                pc = 61'(st_reg[j-1].x2) * 61'(st_reg[j-1].hc);
                st_next[j].vc = pc[59:30];
                if (SL < spc_pkg::N_SIN)
                begin
                    ps = 61'(st_reg[j-1].x2) * 61'(st_reg[j-1].hs);
                    st_next[j].vs = ps[59:30];
                end
                else
                begin
                    ps = 61'(st_reg[j-1].x) * 61'(st_reg[j-1].hs);
                    st_next[j].hs = ps[60:30];
                end
            end
        end
        else if (PH == 1)
        begin : g_est
            if (SL < spc_pkg::N_SIN)
            begin : g_both
                always_comb
                begin
                    logic [61:0] ms;
                    logic [61:0] mc;
                    st_next[j] = st_reg[j-1];
                    ms = 62'(st_reg[j-1].vs) * 62'(spc_pkg::MS[SL]);
                    mc = 62'(st_reg[j-1].vc) * 62'(spc_pkg::MC[SL]);
                    st_next[j].qs = ms[61:32];
                    st_next[j].qc = mc[61:32];
                end
            end
            else
            begin : g_cos
                always_comb
                begin
                    logic [61:0] mc;
                    st_next[j] = st_reg[j-1];
                    mc = 62'(st_reg[j-1].vc) * 62'(spc_pkg::MC[SL]);
                    st_next[j].qc = mc[61:32];
                end
            end
        end
        else
        begin : g_corr
            if (SL < spc_pkg::N_SIN)
            begin : g_both
                always_comb
                begin
                    st_next[j] = st_reg[j-1];
                    st_next[j].hs = hstep(st_reg[j-1].vs, st_reg[j-1].qs, spc_pkg::KS[SL]);
                    st_next[j].hc = hstep(st_reg[j-1].vc, st_reg[j-1].qc, spc_pkg::KC[SL]);
                end
            end
            else
            begin : g_cos
                always_comb
                begin
                    st_next[j] = st_reg[j-1];
                    st_next[j].hc = hstep(st_reg[j-1].vc, st_reg[j-1].qc, spc_pkg::KC[SL]);
                end
            end
        end
    end

    // Advance each stage when its slot is free
    for (genvar j = 0; j < NS; j++)
    begin : g_reg
        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    // Map the folded values back to the full circle
    always_comb
    begin : b_map
        logic signed [31:0] ps;
        logic signed [31:0] pc;
        logic signed [31:0] sv;
        logic signed [31:0] cv;
        sv = $signed({1'b0, st_reg[NS-1].hs});
        cv = $signed({1'b0, st_reg[NS-1].hc});
        ps = st_reg[NS-1].sw ? cv : sv;
        pc = st_reg[NS-1].sw ? sv : cv;
        unique case (st_reg[NS-1].quad)
            2'd0:
            begin
                sin_next = ps;
                cos_next = pc;
            end
            2'd1:
            begin
                sin_next = pc;
                cos_next = -ps;
            end
            2'd2:
            begin
                sin_next = -ps;
                cos_next = -pc;
            end
            default:
            begin
                sin_next = -pc;
                cos_next = ps;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[spc_pkg::SC_DEPTH-1])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// File: hw/rtl/spc_checker.sv
module spc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input spc_pkg::out_item_t out_data
);

    // No item shows while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A free output slot lets the whole pipeline move
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled while the output can move");

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // The input stalls only while the output holds a stalled item
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

endmodule

bind spherical_pv_to_cartesian_core spc_checker u_spc_checker (.*);

// File: verif/spherical_pv_to_cartesian_core_test.sv
`timescale 1ns / 100ps

module spherical_pv_to_cartesian_core_test;

    typedef struct {
        spc_pkg::in_item_t  item;
        bit                 typed;
        spc_pkg::out_item_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    spc_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    spc_pkg::out_item_t out_data;

    spc_pkg::out_item_t cart_q[$];
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    spherical_pv_to_cartesian_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // trunc(a * b / 2^n), exact wide product, magnitude saturated
    function automatic longint scaled_product(longint a, longint b, int unsigned n);
        bit         neg;
        bit [63:0]  ua;
        bit [63:0]  ub;
        bit [63:0]  q;
        bit [127:0] p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = ({64'd0, ua} * {64'd0, ub}) >> n;
        q   = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Sine and cosine in Q2.30 by octant folding and Horner series
    task automatic angle_sincos(input logic [31:0] ang, output longint s, output longint c);
        bit [1:0]  quad;
        bit [63:0] f;
        bit [63:0] g;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] h;
        bit [63:0] sv;
        bit [63:0] cv;
        bit [63:0] ps;
        bit [63:0] pc;
        bit [63:0] unit;
        unit = 64'd1 << 30;
        quad = ang[31:30];
        f    = ang[29:0];
        g    = (f <= (64'd1 << 29)) ? f : unit - f;
        x    = (g * 64'(spc_pkg::PI_Q31)) >> 32;
        x2   = (x * x) >> 30;
        h = unit;
        for (int i = 0; i < spc_pkg::N_SIN; i++)
            h = unit - ((x2 * h) >> 30) / 64'(spc_pkg::KS[i]);
        sv = (x * h) >> 30;
        h = unit;
        for (int i = 0; i < spc_pkg::N_SLOT; i++)
            h = unit - ((x2 * h) >> 30) / 64'(spc_pkg::KC[i]);
        cv = h;
        if (f <= (64'd1 << 29))
        begin
            ps = sv;
            pc = cv;
        end
        else
        begin
            ps = cv;
            pc = sv;
        end
        case (quad)
            2'd0:    begin s = ps;  c = pc;  end
            2'd1:    begin s = pc;  c = -longint'(ps); end
            2'd2:    begin s = -longint'(ps); c = -longint'(pc); end
            default: begin s = -longint'(pc); c = ps;  end
        endcase
    endtask

    // Q32.32 to saturated Q32.16
    function automatic logic [spc_pkg::OUT_BITS-1:0] to_q32_16(longint v);
        longint r;
        longint maxv;
        maxv = (longint'(1) << (spc_pkg::OUT_BITS - 1)) - 1;
        r    = scaled_product(v, 1, 16);
        if (r > maxv)
            r = maxv;
        if (r < -maxv - 1)
            r = -maxv - 1;
        return r[spc_pkg::OUT_BITS-1:0];
    endfunction

    // Cartesian position and velocity of one spherical item
    task automatic predict_cartesian(input spc_pkg::in_item_t it,
                                     output spc_pkg::out_item_t res);
        longint slo, clo, sla, cla;
        longint d, dlo, dla, dd;
        longint dcl, x, y, z, ddl, w, vx, vy, vz;
        d   = it.distance;
        dlo = it.longitude_rate;
        dla = it.latitude_rate;
        dd  = it.distance_rate;
        angle_sincos(it.longitude, slo, clo);
        angle_sincos(it.latitude, sla, cla);
        dcl = scaled_product(d, cla, 14);
        x   = scaled_product(dcl, clo, 30);
        y   = scaled_product(dcl, slo, 30);
        z   = scaled_product(d, sla, 14);
        ddl = scaled_product(d, dla, 12);
        w   = scaled_product(ddl, sla, 30) - scaled_product(dd, cla, 14);
        vx  = -scaled_product(y, dlo, 28) - scaled_product(w, clo, 30);
        vy  = scaled_product(x, dlo, 28) - scaled_product(w, slo, 30);
        vz  = scaled_product(ddl, cla, 30) + scaled_product(dd, sla, 14);
        res.pos_x = to_q32_16(x);
        res.pos_y = to_q32_16(y);
        res.pos_z = to_q32_16(z);
        res.vel_x = to_q32_16(vx);
        res.vel_y = to_q32_16(vy);
        res.vel_z = to_q32_16(vz);
    endtask

    task automatic check_field(string name, logic [spc_pkg::OUT_BITS-1:0] want,
                               logic [spc_pkg::OUT_BITS-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Drive one item and hold it until accepted; optionally idle afterwards
    task automatic send_item(input spc_pkg::in_item_t it, input bit typed,
                             input spc_pkg::out_item_t want);
        spc_pkg::out_item_t res;
        int                 gap;
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (typed)
            res = want;
        else
            predict_cartesian(it, res);
        cart_q.push_back(res);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(2000000)) - 1000000);
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200)) - 100) << $urandom_range(24);
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(4) == 0)
            return {2'($urandom_range(3)), 30'h2000_0000} + 32'($signed($urandom_range(4)) - 2);
        return $urandom;
    endfunction

    // Receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        spc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cart_q.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                fail_count++;
            end
            else
            begin
                want = cart_q.pop_front();
                check_field("pos_x", want.pos_x, out_data.pos_x);
                check_field("pos_y", want.pos_y, out_data.pos_y);
                check_field("pos_z", want.pos_z, out_data.pos_z);
                check_field("vel_x", want.vel_x, out_data.vel_x);
                check_field("vel_y", want.vel_y, out_data.vel_y);
                check_field("vel_z", want.vel_z, out_data.vel_z);
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t          dir_rows[$];
        spc_pkg::out_item_t none;
        spc_pkg::in_item_t  it;
        none = '0;
        dir_rows = '{
            '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b1, '0},
            '{'{32'h0, 32'h0, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
              '{48'sh0000_7FFF_FFFF, 48'sh0, 48'sh0, 48'sh0, 48'sh0, 48'sh0}},
            '{'{32'h0, 32'h0, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
              '{48'shFFFF_8000_0000, 48'sh0, 48'sh0, 48'sh0, 48'sh0, 48'sh0}},
            '{'{32'h4000_0000, 32'h0, 32'sh0001_0000, 32'sh1000_0000, 32'sh0, 32'sh0}, 1'b0, none},
            '{'{32'h8000_0000, 32'h4000_0000, 32'sh0001_0000, 32'sh0, 32'sh1000_0000,
                32'sh0001_0000}, 1'b0, none},
            '{'{32'hC000_0000, 32'hC000_0000, 32'sh0001_0000, 32'sh0, 32'sh0,
                32'sh0001_0000}, 1'b0, none},
            '{'{32'h2000_0000, 32'h2000_0000, 32'sh0010_0000, 32'sh1000_0000, 32'sh1000_0000,
                32'sh1000_0000}, 1'b0, none},
            '{'{32'h2000_0001, 32'h1FFF_FFFF, 32'sh0010_0000, 32'shF000_0000, 32'shF000_0000,
                32'shF000_0000}, 1'b0, none},
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF}, 1'b0, none},
            '{'{32'h6000_0000, 32'hA000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000}, 1'b0, none},
            '{'{32'hE000_0000, 32'h6000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000}, 1'b0, none},
            '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'shFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF,
                32'sh0000_0001}, 1'b0, none},
            '{'{32'h1234_5678, 32'h8765_4321, 32'sh0100_0000, 32'sh0123_4567, 32'shFEDC_BA98,
                32'sh0040_0000}, 1'b0, none}
        };

        fail_count     = 0;
        send_idle_pct  = 26;
        recv_stall_pct = 53;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Hold the sender until the pipeline drains
        in_valid <= 1'b0;
        while (cart_q.size() != 0)
            @(posedge clk);

        // Random items over three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 26 : (phase == 1) ? 53 : 0;
            recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < 130; n++)
            begin
                it.longitude      = rand_angle();
                it.latitude       = rand_angle();
                it.distance       = rand_value();
                it.longitude_rate = rand_value();
                it.latitude_rate  = rand_value();
                it.distance_rate  = rand_value();
                send_item(it, 1'b0, none);
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow the pipeline latency
        while (cart_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: spherical_pv_to_cartesian_core.f
hw/rtl/spc_pkg.sv
hw/rtl/spc_sincos.sv
hw/rtl/spherical_pv_to_cartesian_core.sv
hw/rtl/spc_checker.sv
verif/spherical_pv_to_cartesian_core_test.sv
